>>> hdl/kmds_pkg.sv
// shared types and constants for the key matrix debounce scanner
`default_nettype none
package kmds_pkg;

    localparam int unsigned COL_W      = 4;
    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned DEBOUNCE_W = 20;
    localparam int unsigned MAX_ROWS   = 8;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 20'd5000;

    localparam int unsigned APB_ADDR_W = 2;
    localparam int unsigned APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] ADDR_DEBOUNCE = 2'd0;

    typedef struct packed {
        logic [COL_W-1:0]   column;
        logic [LEVEL_W-1:0] row_levels;
        logic [TIME_W-1:0]  now_us;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } head_t;

    typedef struct packed {
        logic [2:0]       key_row;
        logic [COL_W-1:0] key_column;
        logic             now_pressed;
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_FLUSH = 3'b100
    } scan_state_t;

endpackage
`default_nettype wire

>>> hdl/kmds_if.sv
// channel interfaces for column scans and key events
`default_nettype none
interface kmds_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  column;
    logic [7:0]  row_levels;
    logic [31:0] now_us;

    modport source (output valid, output column, output row_levels, output now_us,
                    input ready);
    modport sink (input valid, input column, input row_levels, input now_us,
                  output ready);
endinterface

interface kmds_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] key_row;
    logic [3:0] key_column;
    logic       now_pressed;
    logic       last_event;

    modport source (output valid, output key_row, output key_column, output now_pressed,
                    output last_event, input ready);
    modport sink (input valid, input key_row, input key_column, input now_pressed,
                  input last_event, output ready);
endinterface
`default_nettype wire

>>> hdl/kmds_ram.sv
// generic single write port ram with registered read
`default_nettype none
module kmds_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule
`default_nettype wire

>>> hdl/kmds_front.sv
// input side: accepts column scans, drops out-of-range columns, two-entry queue
`default_nettype none
module kmds_front #(
    parameter int unsigned COLS = 16
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    kmds_in_if.sink            scan_in,
    output kmds_pkg::head_t    head,
    input  wire logic          pop
);

    kmds_pkg::item_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      count_reg;
    logic            accept;
    logic            in_range;
    logic            push;
    logic            do_pop;

    assign scan_in.ready = (count_reg != 2'd2);
    assign accept        = scan_in.valid && scan_in.ready;
    assign in_range      = ({28'd0, scan_in.column} < 32'(COLS));
    assign push          = accept && in_range;
    assign do_pop        = pop && (count_reg != 2'd0);

    assign head.valid = (count_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{column: scan_in.column,
                                       row_levels: scan_in.row_levels,
                                       now_us: scan_in.now_us};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (!push && do_pop)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule
`default_nettype wire

>>> hdl/kmds_back.sv
// back end: walks the rows of one column, debounces each key, emits events
`default_nettype none
module kmds_back #(
    parameter int unsigned ROWS = 8,
    parameter int unsigned COLS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire kmds_pkg::head_t                   head,
    output logic                                   pop,
    input  wire logic [kmds_pkg::DEBOUNCE_W-1:0]   debounce_us,
    kmds_out_if.source                             key_out
);

    localparam int unsigned SCAN_ROWS = (ROWS < kmds_pkg::MAX_ROWS) ? ROWS : kmds_pkg::MAX_ROWS;
    localparam int unsigned RW        = (SCAN_ROWS > 1) ? $clog2(SCAN_ROWS) : 1;
    localparam int unsigned CW        = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int unsigned AW        = CW + RW;
    localparam int unsigned DEPTH     = 1 << AW;

    kmds_pkg::scan_state_t state_reg, state_next;

    logic [SCAN_ROWS-1:0]          stable_reg [COLS];
    logic [SCAN_ROWS-1:0]          armed_reg  [COLS];
    logic [CW-1:0]                 col_reg;
    logic [RW-1:0]                 row_reg;
    logic [SCAN_ROWS-1:0]          lev_reg;
    logic [kmds_pkg::TIME_W-1:0]   now_reg;
    kmds_pkg::event_t              pend_reg;
    logic                          pend_valid_reg;
    kmds_pkg::event_t              out_reg;
    logic                          out_last_reg;
    logic                          out_valid_reg;

    logic                          level;
    logic                          st;
    logic                          ar;
    logic                          diff;
    logic                          arm;
    logic                          fire;
    logic [kmds_pkg::TIME_W-1:0]   start_time;
    logic [kmds_pkg::TIME_W-1:0]   elapsed;
    logic                          last_row;
    logic                          can_push;
    logic                          need_push;
    logic                          advance;
    logic                          push;
    logic                          push_last;
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [AW-1:0]                 ram_raddr;

    assign level    = lev_reg[row_reg];
    assign st       = stable_reg[col_reg][row_reg];
    assign ar       = armed_reg[col_reg][row_reg];
    assign diff     = (level != st);
    assign arm      = diff && !ar;
    assign elapsed  = now_reg - start_time;
    assign fire     = diff && ar && (elapsed > {12'd0, debounce_us});
    assign last_row = (row_reg == RW'(SCAN_ROWS - 1));
    assign can_push = !out_valid_reg || key_out.ready;

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        need_push  = 1'b0;
        advance    = 1'b0;
        push       = 1'b0;
        push_last  = 1'b0;
        ram_raddr  = {col_reg, row_reg};
        case (state_reg)
            kmds_pkg::ST_IDLE:
            begin
                ram_raddr = {CW'(head.item.column), RW'(0)};
                if (head.valid)
                begin
                    pop        = 1'b1;
                    state_next = kmds_pkg::ST_SCAN;
                end
            end
            kmds_pkg::ST_SCAN:
            begin
                need_push = pend_valid_reg && (fire || last_row);
                advance   = !(need_push && !can_push);
                push      = advance && need_push;
                push_last = !fire;
                if (advance)
                begin
                    ram_raddr = {col_reg, row_reg + RW'(1)};
                    if (last_row)
                    begin
                        state_next = fire ? kmds_pkg::ST_FLUSH : kmds_pkg::ST_IDLE;
                    end
                end
            end
            kmds_pkg::ST_FLUSH:
            begin
                push      = can_push;
                push_last = 1'b1;
                if (can_push)
                begin
                    state_next = kmds_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kmds_pkg::ST_IDLE;
            end
        endcase
    end

    assign ram_we    = advance && arm;
    assign ram_waddr = {col_reg, row_reg};

    kmds_ram #(
        .WIDTH (kmds_pkg::TIME_W),
        .DEPTH (DEPTH)
    ) u_start_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (now_reg),
        .raddr (ram_raddr),
        .rdata (start_time)
    );

    // item, pending event and output event payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            col_reg <= CW'(head.item.column);
            lev_reg <= head.item.row_levels[SCAN_ROWS-1:0];
            now_reg <= head.item.now_us;
        end
        if (advance && fire)
        begin
            pend_reg <= '{key_row: 3'(row_reg), key_column: 4'(col_reg), now_pressed: ~st};
        end
        if (push)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= push_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kmds_pkg::ST_IDLE;
            row_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int c = 0; c < COLS; c++)
            begin
                stable_reg[c] <= '0;
                armed_reg[c]  <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                row_reg <= '0;
            end
            else if (advance)
            begin
                row_reg <= row_reg + RW'(1);
                stable_reg[col_reg][row_reg] <= st ^ fire;
                armed_reg[col_reg][row_reg]  <= diff && !fire;
            end
            if (advance && fire)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (push)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (key_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign key_out.valid       = out_valid_reg;
    assign key_out.key_row     = out_reg.key_row;
    assign key_out.key_column  = out_reg.key_column;
    assign key_out.now_pressed = out_reg.now_pressed;
    assign key_out.last_event  = out_last_reg;

endmodule
`default_nettype wire

>>> hdl/key_matrix_debounce_scanner_core.sv
// top level of the key matrix debounce scanner
//
// scan_in carries one strobed column per transfer: column index, row levels
// and a free-running 32-bit microsecond time. key_out carries one transfer per
// key whose debounced state flips: row, column, new state and a last marker
// on the final event of a column. A column at or above COLS is taken and
// dropped. A two-entry queue sits behind scan_in, so the source can run
// ahead of the row walk.
// The row walk loads a column in the idle state, checks each scanned row
// (min(ROWS, 8)) in the scan state, and adds a flush step when the last row
// produces an event. The start-time ram is read one row ahead, so the row
// checks do not wait on the read. A found event waits in a pending register
// until the next event fires or the last row is checked, then moves to key_out.
// A stall on key_out holds the row walk at the next event, or at the last row while
// an event is pending; the queue then fills and scan_in.ready drops.
// Reset clears all pressed and armed bits and loads debounce_us with 5000;
// start times need no clearing since they are read only for armed keys.
// debounce_us sits at apb address 0.
`default_nettype none
module key_matrix_debounce_scanner_core #(
    parameter int unsigned ROWS = 8,
    parameter int unsigned COLS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    kmds_in_if.sink                                scan_in,
    kmds_out_if.source                             key_out,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [kmds_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [kmds_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [kmds_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    logic [kmds_pkg::DEBOUNCE_W-1:0] debounce_reg;
    kmds_pkg::head_t                 head;
    logic                            pop;

    assign pready = 1'b1;
    assign prdata = (paddr == kmds_pkg::ADDR_DEBOUNCE) ? {12'd0, debounce_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= kmds_pkg::DEBOUNCE_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == kmds_pkg::ADDR_DEBOUNCE))
        begin
            debounce_reg <= pwdata[kmds_pkg::DEBOUNCE_W-1:0];
        end
    end

    kmds_front #(
        .COLS (COLS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan_in (scan_in),
        .head    (head),
        .pop     (pop)
    );

    kmds_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop         (pop),
        .debounce_us (debounce_reg),
        .key_out     (key_out)
    );

endmodule
`default_nettype wire

>>> bench/kmds_checker.sv
// checker for the key matrix debounce scanner: predicts key events and compares them
`default_nettype none
module kmds_checker
    import kmds_pkg::*;
#(
    parameter int unsigned ROWS = 8,
    parameter int unsigned COLS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    kmds_in_if                         scan,
    kmds_out_if                        events,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic [APB_DATA_W-1:0] prdata,
    input  wire logic                  pready,
    output int unsigned                fail_count,
    output int unsigned                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SCAN_ROWS = (ROWS < MAX_ROWS) ? ROWS : MAX_ROWS;
    localparam int unsigned KEYS      = ROWS * COLS;

    typedef struct packed {
        event_t change;
        logic   last_event;
    } key_change_t;

    logic                  pressed_q [KEYS];
    logic                  armed_q   [KEYS];
    logic [TIME_W-1:0]     armed_at  [KEYS];
    logic [DEBOUNCE_W-1:0] debounce_us;
    key_change_t           expected_q [$];

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic predict_scan(input logic [COL_W-1:0] col, input logic [LEVEL_W-1:0] levels,
                                input logic [TIME_W-1:0] now);
        int unsigned r;
        int unsigned k;
        int unsigned found;
        logic [TIME_W-1:0] elapsed;
        key_change_t ch;
        found = 0;
        if (col < COLS) begin
            for (r = 0; r < SCAN_ROWS; r++) begin
                k = r * COLS + col;
                if (levels[r] != pressed_q[k]) begin
                    if (!armed_q[k]) begin
                        armed_q[k]  = 1'b1;
                        armed_at[k] = now;
                    end else begin
                        elapsed = now - armed_at[k];
                        if (elapsed > {{(TIME_W-DEBOUNCE_W){1'b0}}, debounce_us}) begin
                            pressed_q[k] = ~pressed_q[k];
                            armed_q[k]   = 1'b0;
                            ch.change.key_row     = r[2:0];
                            ch.change.key_column  = col;
                            ch.change.now_pressed = pressed_q[k];
                            ch.last_event         = 1'b0;
                            expected_q.push_back(ch);
                            found++;
                        end
                    end
                end else begin
                    armed_q[k] = 1'b0;
                end
            end
        end
        if (found != 0)
            expected_q[expected_q.size()-1].last_event = 1'b1;
    endtask

    task automatic check_event();
        key_change_t got;
        key_change_t want;
        got.change.key_row     = events.key_row;
        got.change.key_column  = events.key_column;
        got.change.now_pressed = events.now_pressed;
        got.last_event         = events.last_event;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected event row %0d col %0d pressed %0b last %0b",
                got.change.key_row, got.change.key_column, got.change.now_pressed,
                got.last_event));
            return;
        end
        want = expected_q.pop_front();
        if (got.change.key_row !== want.change.key_row
            || got.change.key_column !== want.change.key_column
            || got.change.now_pressed !== want.change.now_pressed
            || got.last_event !== want.last_event)
            report_mismatch($sformatf(
                "event row %0d col %0d pressed %0b last %0b, want row %0d col %0d pressed %0b last %0b",
                got.change.key_row, got.change.key_column, got.change.now_pressed,
                got.last_event, want.change.key_row, want.change.key_column,
                want.change.now_pressed, want.last_event));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < KEYS; i++)
            begin
                pressed_q[i] = 1'b0;
                armed_q[i]   = 1'b0;
            end
            debounce_us = DEBOUNCE_RESET;
            expected_q.delete();
            outstanding = 0;
            fail_count  = 0;
        end else begin
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr == ADDR_DEBOUNCE)
                        debounce_us = pwdata[DEBOUNCE_W-1:0];
                end else if (paddr == ADDR_DEBOUNCE
                             && prdata !== {{(APB_DATA_W-DEBOUNCE_W){1'b0}}, debounce_us}) begin
                    report_mismatch($sformatf("debounce_us read %0h, want %0h",
                        prdata, debounce_us));
                end
            end
            if (scan.valid && scan.ready)
                predict_scan(scan.column, scan.row_levels, scan.now_us);
            if (events.valid && events.ready)
                check_event();
            outstanding = expected_q.size();
        end
    end

endmodule
`default_nettype wire

>>> bench/tb_key_matrix_debounce_scanner_core.sv
// testbench top for the key matrix debounce scanner: stimulus, reset and verdict
`default_nettype none
module tb_key_matrix_debounce_scanner_core;
    timeunit 1ns;
    timeprecision 1ps;
    import kmds_pkg::*;

    localparam int unsigned ROWS           = 8;
    localparam int unsigned COLS           = 16;
    localparam int unsigned IDLE_PCT       = 34;
    localparam int unsigned WATCHDOG_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES   = 80;
    localparam int unsigned PHASE_ITEMS    = 70;

    logic                  clk   = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    int unsigned           fail_count;
    int unsigned           outstanding;
    int unsigned           quiet_cycles = 0;
    bit                    calm = 1'b0;
    logic [DEBOUNCE_W-1:0] debounce_set;
    logic [TIME_W-1:0]     clock_us;
    logic [LEVEL_W-1:0]    held_rows [1 << COL_W];

    kmds_in_if  scan_if ();
    kmds_out_if event_if ();

    key_matrix_debounce_scanner_core #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan_in (scan_if),
        .key_out (event_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    kmds_checker #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .scan        (scan_if),
        .events      (event_if),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #4 clk = ~clk;

    always @(negedge clk)
        event_if.ready = calm || ($urandom_range(0, 99) >= IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((scan_if.valid && scan_if.ready) || (event_if.valid && event_if.ready) || psel)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    task automatic send_scan(input logic [COL_W-1:0] col, input logic [LEVEL_W-1:0] levels,
                             input logic [TIME_W-1:0] now);
        @(negedge clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            scan_if.valid = 1'b0;
            @(negedge clk);
        end
        scan_if.valid      = 1'b1;
        scan_if.column     = col;
        scan_if.row_levels = levels;
        scan_if.now_us     = now;
        @(posedge clk);
        while (!scan_if.ready)
            @(posedge clk);
    endtask

    task automatic apb_access(input logic write, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        scan_if.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_debounce(input logic [APB_DATA_W-1:0] value);
        drain();
        apb_access(1'b1, ADDR_DEBOUNCE, value);
        apb_access(1'b0, ADDR_DEBOUNCE, '0);
        debounce_set = value[DEBOUNCE_W-1:0];
    endtask

    task automatic random_scans(input int unsigned count);
        logic [COL_W-1:0]   col;
        logic [LEVEL_W-1:0] levels;
        logic [TIME_W-1:0]  step;
        int unsigned        roll;
        for (int unsigned i = 0; i < count; i++)
        begin
            col = COL_W'($urandom_range(0, (1 << COL_W) - 1));
            if ($urandom_range(0, 99) < 20)
                held_rows[col] = LEVEL_W'($urandom);
            levels = ($urandom_range(0, 99) < 15) ? LEVEL_W'($urandom) : held_rows[col];
            roll = $urandom_range(0, 99);
            if (roll < 10)
                step = '0;
            else if (roll < 12)
                step = $urandom;
            else
                step = $urandom_range(0, debounce_set / 4 + 4);
            clock_us = clock_us + step;
            send_scan(col, levels, clock_us);
        end
    endtask

    initial
    begin
        logic [APB_DATA_W-1:0] cfg;
        scan_if.valid      = 1'b0;
        scan_if.column     = '0;
        scan_if.row_levels = '0;
        scan_if.now_us     = '0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        debounce_set       = DEBOUNCE_RESET;
        for (int i = 0; i < (1 << COL_W); i++)
            held_rows[i] = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset value, strict greater-than, wrap of the time counter
        apb_access(1'b0, ADDR_DEBOUNCE, '0);
        send_scan(4'd0, 8'hFF, 32'hFFFF_F000);
        send_scan(4'd0, 8'hFF, 32'hFFFF_F000 + 32'd5000);
        send_scan(4'd0, 8'hFF, 32'hFFFF_F000 + 32'd5001);
        send_scan(4'd15, 8'hAA, 32'd100);
        send_scan(4'd15, 8'h0A, 32'd6000);
        send_scan(4'd15, 8'hA0, 32'd6000);
        send_scan(4'd15, 8'hA0, 32'd11001);
        send_scan(4'd0, 8'h00, 32'd20000);
        send_scan(4'd0, 8'h0F, 32'd20100);
        send_scan(4'd0, 8'h00, 32'd30000);
        send_scan(4'd0, 8'h00, 32'd35001);
        send_scan(4'd7, 8'h80, 32'hFFFF_FFFF);
        send_scan(4'd7, 8'h80, 32'hFFFF_FFFF + 32'd5001);

        // zero debounce
        set_debounce(32'd0);
        send_scan(4'd9, 8'h55, 32'd500);
        send_scan(4'd9, 8'h55, 32'd500);
        send_scan(4'd9, 8'h55, 32'd501);

        // largest debounce, upper bits of the write masked off
        set_debounce(32'hFFFF_FFFF);
        send_scan(4'd4, 8'h3C, 32'd0);
        send_scan(4'd4, 8'h3C, 32'h000F_FFFF);
        send_scan(4'd4, 8'h3C, 32'h0010_0000);

        clock_us = $urandom;
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: cfg = 32'd1;
                1: cfg = $urandom_range(2, 3000);
                2: cfg = 32'd0;
                3: cfg = 32'h000F_FFFF;
                default: cfg = $urandom;
            endcase
            set_debounce(cfg);
            calm = (p == 2);
            random_scans(PHASE_ITEMS);
            calm = 1'b0;
        end

        drain();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
hdl/kmds_pkg.sv
hdl/kmds_if.sv
hdl/kmds_ram.sv
hdl/kmds_front.sv
hdl/kmds_back.sv
hdl/key_matrix_debounce_scanner_core.sv
bench/kmds_checker.sv
bench/tb_key_matrix_debounce_scanner_core.sv
